// ===== rtl/idxl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idxl_pkg
// Shared constants, request and status codes and the edit command for the
// indexed list engine.
// ----------------------------------------------------------------------------
package idxl_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int VALUE_WIDTH_DEF = 16;

	// field widths of the stream payload
	localparam int REQ_W    = 3;
	localparam int VAL_W    = 16;
	localparam int POS_W    = 4;
	localparam int STAT_W   = 2;
	localparam int IDXO_W   = 4;
	localparam int CNTO_W   = 5;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 64;

	localparam logic [REQ_W-1:0] REQ_INSERT_AT    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_APPEND       = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SORTED       = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE_AT    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_REMOVE_VALUE = 3'd4;
	localparam logic [REQ_W-1:0] REQ_FIND         = 3'd5;
	localparam logic [REQ_W-1:0] REQ_READ_AT      = 3'd6;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_POS   = 2'd3;

	// one-cycle edit broadcast to every cell
	typedef struct packed {
		logic ins;  // open a gap at the edit position and write the key there
		logic del;  // close the entry at the edit position
	} idxl_edit_t;

endpackage

// ===== rtl/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded ordered list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// One request is handled at a time. A scan token walks the cell chain once to
// locate the match, the first larger entry and the read position. All cells
// then shift together in the edit cycle, and a second walk of the chain
// gathers the minimum and maximum of the updated list. The next request is
// taken only once the result has been loaded into the output register, so a
// request is never accepted while the one before it is still in progress.
// The result sits in an output register, so a new request is taken while it
// waits; if the previous result is still unaccepted when the next one is
// ready, the engine holds in its final state until the register frees up.
// ----------------------------------------------------------------------------
module indexed_list_engine
	import idxl_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // value[15:0], position[19:16], zero fill
	input  logic [REQ_W-1:0]    s_tuser,   // req_type[2:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // value_out[15:0], index_out[19:16],
	                                       // entry_count[24:20], min_value[40:25],
	                                       // max_value[56:41], zero fill
	output logic [STAT_W-1:0]   m_tuser    // status[1:0]
);

	localparam int VW    = VALUE_WIDTH;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PASS1 = 3'd1;
	localparam logic [2:0] ST_APPLY = 3'd2;
	localparam logic [2:0] ST_PASS2 = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};

	logic [2:0]           state_q;
	logic                 start_q;
	logic [REQ_W-1:0]     req_q;
	logic signed [VW-1:0] key_q;
	logic [POS_W-1:0]     pos_q;
	logic [CNT_W-1:0]     count_q;
	logic [STAT_W-1:0]    res_status_q;
	logic [VAL_W-1:0]     res_val_q;
	logic [IDXO_W-1:0]    res_idx_q;
	logic                 m_tvalid_q;
	logic [M_DATA_W-1:0]  m_tdata_q;
	logic [STAT_W-1:0]    m_tuser_q;

	// chain links, link i feeds cell i
	logic signed [VW-1:0] entry_c [DEPTH];
	logic                 tok_c   [DEPTH+1];
	logic signed [VW-1:0] min_c   [DEPTH+1];
	logic signed [VW-1:0] max_c   [DEPTH+1];
	logic                 hit_c   [DEPTH+1];
	logic [IW-1:0]        hidx_c  [DEPTH+1];
	logic                 gt_c    [DEPTH+1];
	logic [IW-1:0]        gidx_c  [DEPTH+1];
	logic signed [VW-1:0] rd_c    [DEPTH+1];
	logic [DEPTH-1:0]     tok_v;

	idxl_edit_t           edit;
	logic [CW-1:0]        edit_pos;
	logic [STAT_W-1:0]    status_d;
	logic [CNT_W-1:0]     count_d;
	logic [CW-1:0]        cnt_x, pos_x;
	logic                 full, in_xfer, out_free, chain_done;
	logic [VAL_W-1:0]     min_o, max_o;

	assign s_tready   = state_q == ST_IDLE;
	assign in_xfer    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign chain_done = tok_c[DEPTH];
	assign cnt_x      = CW'(count_q);
	assign pos_x      = CW'(pos_q);
	assign full       = count_q == CNT_W'(DEPTH);

	assign tok_c[0]  = start_q;
	assign min_c[0]  = MOST_POS;
	assign max_c[0]  = MOST_NEG;
	assign hit_c[0]  = 1'b0;
	assign hidx_c[0] = '0;
	assign gt_c[0]   = 1'b0;
	assign gidx_c[0] = '0;
	assign rd_c[0]   = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VW-1:0] left_e, right_e;
		if (i == 0) begin : g_first
			assign left_e = key_q;
		end else begin : g_left
			assign left_e = entry_c[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_e = entry_c[i];
		end else begin : g_right
			assign right_e = entry_c[i+1];
		end

		idxl_cell #(
			.VW (VW),
			.IW (IW),
			.CW (CW),
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.edit       (edit),
			.edit_pos   (edit_pos),
			.key        (key_q),
			.left_entry (left_e),
			.right_entry(right_e),
			.entry      (entry_c[i]),
			.count      (cnt_x),
			.rd_pos     (pos_x),
			.tok_in     (tok_c[i]),
			.min_in     (min_c[i]),
			.max_in     (max_c[i]),
			.hit_in     (hit_c[i]),
			.hidx_in    (hidx_c[i]),
			.gt_in      (gt_c[i]),
			.gidx_in    (gidx_c[i]),
			.rd_in      (rd_c[i]),
			.tok_out    (tok_c[i+1]),
			.min_out    (min_c[i+1]),
			.max_out    (max_c[i+1]),
			.hit_out    (hit_c[i+1]),
			.hidx_out   (hidx_c[i+1]),
			.gt_out     (gt_c[i+1]),
			.gidx_out   (gidx_c[i+1]),
			.rd_out     (rd_c[i+1])
		);

		assign tok_v[i] = tok_c[i+1];
	end

	// decision from the first scan, applied in the edit cycle
	always_comb begin
		edit     = '0;
		edit_pos = '0;
		status_d = STAT_OK;
		count_d  = count_q;
		unique case (req_q)
			REQ_INSERT_AT: begin
				if (full) begin
					status_d = STAT_FULL;
				end else if (pos_x > cnt_x) begin
					status_d = STAT_BAD_POS;
				end else begin
					edit.ins = 1'b1;
					edit_pos = pos_x;
				end
			end
			REQ_APPEND: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					edit.ins = 1'b1;
					edit_pos = cnt_x;
				end
			end
			REQ_SORTED: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					edit.ins = 1'b1;
					edit_pos = gt_c[DEPTH] ? CW'(gidx_c[DEPTH]) : cnt_x;
				end
			end
			REQ_REMOVE_AT: begin
				if (pos_x >= cnt_x) begin
					status_d = STAT_BAD_POS;
				end else begin
					edit.del = 1'b1;
					edit_pos = pos_x;
				end
			end
			REQ_REMOVE_VALUE: begin
				if (hit_c[DEPTH]) begin
					edit.del = 1'b1;
					edit_pos = CW'(hidx_c[DEPTH]);
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
			REQ_FIND: begin
				if (!hit_c[DEPTH]) begin
					status_d = STAT_NOT_FOUND;
				end
			end
			REQ_READ_AT: begin
				if (pos_x >= cnt_x) begin
					status_d = STAT_BAD_POS;
				end
			end
			default: begin
			end
		endcase
		if (state_q != ST_APPLY) begin
			edit = '0;
		end
		if (edit.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (edit.del) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			start_q    <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// launch a scan on acceptance and again after the edit
			start_q <= in_xfer || (state_q == ST_APPLY);
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_PASS1;
					end
				end
				ST_PASS1: begin
					if (chain_done) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					count_q <= count_d;
					state_q <= ST_PASS2;
				end
				ST_PASS2: begin
					if (chain_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign min_o = (count_q == '0) ? '1 : VAL_W'(min_c[DEPTH]);
	assign max_o = (count_q == '0) ? '1 : VAL_W'(max_c[DEPTH]);

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_q <= s_tuser;
			key_q <= VW'(signed'(s_tdata[VAL_W-1:0]));
			pos_q <= s_tdata[VAL_W +: POS_W];
		end
		if (state_q == ST_APPLY) begin
			res_status_q <= status_d;
			res_val_q    <= (req_q == REQ_READ_AT && status_d == STAT_OK) ?
			                VAL_W'(rd_c[DEPTH]) : '0;
			res_idx_q    <= (req_q == REQ_FIND && status_d == STAT_OK) ?
			                IDXO_W'(hidx_c[DEPTH]) : '0;
		end
		if (state_q == ST_OUT && out_free) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= {7'd0, max_o, min_o, CNTO_W'(count_q), res_idx_q, res_val_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// no scan token may be in flight while the engine waits for a request
	a_idle_no_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (tok_v == '0 && !start_q))
		else $error("scan token in flight while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// only the edit cycle may change the entry count
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) != ST_APPLY) |-> $stable(count_q))
		else $error("entry count changed outside the edit cycle");

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one scan token in the chain");

endmodule

// ===== rtl/idxl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idxl_cell
// One list slot: holds an entry, shifts with its neighbours on an edit and
// folds its entry into the scan transaction passing down the chain.
// ----------------------------------------------------------------------------
module idxl_cell
	import idxl_pkg::*;
#(
	parameter int VW  = VALUE_WIDTH_DEF,
	parameter int IW  = 4,
	parameter int CW  = 5,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// edit
	input  idxl_edit_t           edit,
	input  logic [CW-1:0]        edit_pos,
	input  logic signed [VW-1:0] key,
	input  logic signed [VW-1:0] left_entry,
	input  logic signed [VW-1:0] right_entry,
	output logic signed [VW-1:0] entry,
	// scan
	input  logic [CW-1:0]        count,
	input  logic [CW-1:0]        rd_pos,
	input  logic                 tok_in,
	input  logic signed [VW-1:0] min_in,
	input  logic signed [VW-1:0] max_in,
	input  logic                 hit_in,
	input  logic [IW-1:0]        hidx_in,
	input  logic                 gt_in,
	input  logic [IW-1:0]        gidx_in,
	input  logic signed [VW-1:0] rd_in,
	output logic                 tok_out,
	output logic signed [VW-1:0] min_out,
	output logic signed [VW-1:0] max_out,
	output logic                 hit_out,
	output logic [IW-1:0]        hidx_out,
	output logic                 gt_out,
	output logic [IW-1:0]        gidx_out,
	output logic signed [VW-1:0] rd_out
);

	localparam logic [CW-1:0] MY_POS = CW'(IDX);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [VW-1:0] entry_q;
	logic                 tok_q;
	logic signed [VW-1:0] min_q, max_q, rd_q;
	logic                 hit_q, gt_q;
	logic [IW-1:0]        hidx_q, gidx_q;
	logic                 live, at_pos, past_pos;

	assign live     = MY_POS < count;
	assign at_pos   = MY_POS == edit_pos;
	assign past_pos = MY_POS > edit_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (edit.ins) begin
			if (at_pos) begin
				entry_q <= key;
			end else if (past_pos) begin
				entry_q <= left_entry;
			end
		end else if (edit.del) begin
			if (at_pos || past_pos) begin
				entry_q <= right_entry;
			end
		end
		// scan fields only move with the token, so the chain end holds its result
		if (tok_in) begin
			min_q  <= (live && entry_q < min_in) ? entry_q : min_in;
			max_q  <= (live && entry_q > max_in) ? entry_q : max_in;
			hit_q  <= hit_in || (live && entry_q == key);
			hidx_q <= hit_in ? hidx_in : MY_IDX;
			gt_q   <= gt_in || (live && entry_q > key);
			gidx_q <= gt_in ? gidx_in : MY_IDX;
			rd_q   <= (MY_POS == rd_pos) ? entry_q : rd_in;
		end
	end

	assign entry    = entry_q;
	assign tok_out  = tok_q;
	assign min_out  = min_q;
	assign max_out  = max_q;
	assign hit_out  = hit_q;
	assign hidx_out = hidx_q;
	assign gt_out   = gt_q;
	assign gidx_out = gidx_q;
	assign rd_out   = rd_q;

endmodule

// ===== sim/indexed_list_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// Self-checking bench for the indexed list engine. Requests go in on the
// slave stream and a local model of the list predicts each result: status,
// read value, found index, count, minimum and maximum. Directed tests cover
// the empty list, every edit and query, the full list and the position
// limits. A long random run then fills and drains the list with random gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module indexed_list_engine_test;
	import idxl_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  value_out;
		logic [IDXO_W-1:0] index_out;
		logic [CNTO_W-1:0] entry_count;
		logic [VAL_W-1:0]  min_value;
		logic [VAL_W-1:0]  max_value;
	} list_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [REQ_W-1:0]    s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]   m_tuser;

	// predicted list contents and the results still owed by the block
	logic signed [VAL_W-1:0] list_q[$];
	list_result_t            pending_results[$];
	int                      mismatch_count = 0;
	bit                      tx_quiet = 1'b0;
	bit                      rx_quiet = 1'b0;

	indexed_list_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

	// applies one request to the predicted list and returns the result it owes
	function automatic list_result_t apply_request(input logic [REQ_W-1:0] kind,
			input logic signed [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		list_result_t res;
		int count;
		int slot;
		int hit;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		res = '0;
		count = list_q.size();
		hit = -1;
		for (int i = count - 1; i >= 0; i--) begin
			if (list_q[i] == val) hit = i;
		end
		case (kind)
			REQ_INSERT_AT: begin
				if (count >= LIST_DEPTH) res.status = STAT_FULL;
				else if (pos > count) res.status = STAT_BAD_POS;
				else list_q.insert(pos, val);
			end
			REQ_APPEND: begin
				if (count >= LIST_DEPTH) res.status = STAT_FULL;
				else list_q.push_back(val);
			end
			REQ_SORTED: begin
				if (count >= LIST_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					// in front of the first strictly greater entry, else at the end
					slot = count;
					for (int i = count - 1; i >= 0; i--) begin
						if (list_q[i] > val) slot = i;
					end
					list_q.insert(slot, val);
				end
			end
			REQ_REMOVE_AT: begin
				if (pos >= count) res.status = STAT_BAD_POS;
				else list_q.delete(pos);
			end
			REQ_REMOVE_VALUE: begin
				if (hit < 0) res.status = STAT_NOT_FOUND;
				else list_q.delete(hit);
			end
			REQ_FIND: begin
				if (hit < 0) res.status = STAT_NOT_FOUND;
				else res.index_out = IDXO_W'(hit);
			end
			REQ_READ_AT: begin
				if (pos >= count) res.status = STAT_BAD_POS;
				else res.value_out = list_q[pos];
			end
			default: ;
		endcase
		lo = '1;
		hi = '1;
		if (list_q.size() > 0) begin
			lo = list_q[0];
			hi = list_q[0];
			foreach (list_q[i]) begin
				if (list_q[i] < lo) lo = list_q[i];
				if (list_q[i] > hi) hi = list_q[i];
			end
		end
		res.entry_count = CNTO_W'(list_q.size());
		res.min_value = lo;
		res.max_value = hi;
		return res;
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [VAL_W-1:0] val,
			input logic [POS_W-1:0] pos);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_DATA_W - VAL_W - POS_W){1'b0}}, pos, val};
		s_tuser <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		pending_results.push_back(apply_request(kind, val, pos));
	endtask

	// holds the request side off until every owed result has come back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_list();
		send_request(REQ_READ_AT, 16'sd0, 4'd0);
		send_request(REQ_REMOVE_AT, 16'sd0, 4'd0);
		send_request(REQ_FIND, 16'sd0, 4'd0);
		send_request(REQ_REMOVE_VALUE, -16'sd1, 4'd0);
		send_request(REQ_UNUSED, 16'hFFFF, 4'd15);
		send_request(REQ_INSERT_AT, 16'sd5, 4'd1);
	endtask

	task automatic test_edit_ops();
		send_request(REQ_INSERT_AT, 16'sh7FFF, 4'd0);
		send_request(REQ_APPEND, 16'sh8000, 4'd0);
		// sorted inserts: front, after its equal at the end, and in the middle
		send_request(REQ_SORTED, 16'sd0, 4'd0);
		send_request(REQ_SORTED, 16'sh7FFF, 4'd0);
		send_request(REQ_SORTED, 16'sd100, 4'd0);
		send_request(REQ_FIND, 16'sh7FFF, 4'd0);
		send_request(REQ_READ_AT, 16'sd0, 4'd2);
		send_request(REQ_READ_AT, 16'sd0, 4'd15);
		send_request(REQ_INSERT_AT, 16'sd7, 4'd5);
		send_request(REQ_REMOVE_VALUE, 16'sh7FFF, 4'd0);
		send_request(REQ_REMOVE_AT, 16'sd0, 4'd0);
		send_request(REQ_REMOVE_AT, 16'sd0, 4'd3);
		send_request(REQ_FIND, 16'sh8000, 4'd0);
		wait_for_drain();
	endtask

	task automatic test_full_list();
		int k;
		k = 0;
		while (list_q.size() < LIST_DEPTH) begin
			send_request(REQ_APPEND, VAL_W'((k[0] ? 16'h5555 : 16'hAAAA) ^ k), 4'd0);
			k++;
		end
		// a full list reports full at any insert position
		send_request(REQ_INSERT_AT, 16'sd1, 4'd15);
		send_request(REQ_INSERT_AT, 16'sd1, 4'd0);
		send_request(REQ_APPEND, 16'sd1, 4'd0);
		send_request(REQ_SORTED, 16'sd1, 4'd0);
		send_request(REQ_READ_AT, 16'sd0, 4'd15);
		send_request(REQ_FIND, list_q[LIST_DEPTH - 1], 4'd0);
		send_request(REQ_REMOVE_AT, 16'sd0, 4'd15);
		send_request(REQ_INSERT_AT, 16'sh8000, 4'd15);
		send_request(REQ_REMOVE_VALUE, list_q[7], 4'd0);
	endtask

	task automatic test_random_traffic(input int n_items);
		logic [REQ_W-1:0] kind;
		logic [VAL_W-1:0] val;
		logic [POS_W-1:0] pos;
		int count;
		int roll;
		bit growing;
		growing = (list_q.size() < LIST_DEPTH / 2);
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
				rx_quiet = ($urandom_range(0, 3) == 0);
			end
			if (k == n_items / 2) wait_for_drain();
			count = list_q.size();
			// swing between filling and draining so both ends get hit
			if (growing && count == LIST_DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
			else if (!growing && count == 0 && $urandom_range(0, 3) == 0) growing = 1'b1;
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				kind = REQ_UNUSED;
			end else if (roll < (growing ? 62 : 22)) begin
				case ($urandom_range(0, 2))
					0: kind = REQ_INSERT_AT;
					1: kind = REQ_APPEND;
					default: kind = REQ_SORTED;
				endcase
			end else if (roll < 80) begin
				kind = $urandom_range(0, 1) ? REQ_REMOVE_AT : REQ_REMOVE_VALUE;
			end else begin
				kind = $urandom_range(0, 1) ? REQ_FIND : REQ_READ_AT;
			end
			roll = $urandom_range(0, 99);
			if (roll < 60 && count > 0) val = list_q[$urandom_range(0, count - 1)];
			else if (roll < 85) val = VAL_W'(int'($urandom_range(0, 16)) - 8);
			else val = VAL_W'($urandom);
			if ($urandom_range(0, 4) != 0)
				pos = POS_W'($urandom_range(0, (count > 15) ? 15 : count));
			else pos = POS_W'($urandom_range(0, 15));
			send_request(kind, val, pos);
		end
	endtask

	initial begin : result_sink
		list_result_t got;
		list_result_t want;
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_quiet ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.status = m_tuser;
			got.value_out = m_tdata[15:0];
			got.index_out = m_tdata[19:16];
			got.entry_count = m_tdata[24:20];
			got.min_value = m_tdata[40:25];
			got.max_value = m_tdata[56:41];
			if (pending_results.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result transaction at %0t ns", $realtime);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10) begin
						$display("result mismatch at %0t ns", $realtime);
						$display("  expected st=%0d val=%h idx=%0d cnt=%0d min=%h max=%h",
							want.status, want.value_out, want.index_out, want.entry_count,
							want.min_value, want.max_value);
						$display("  actual   st=%0d val=%h idx=%0d cnt=%0d min=%h max=%h",
							got.status, got.value_out, got.index_out, got.entry_count,
							got.min_value, got.max_value);
					end
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_ops();
		test_full_list();
		test_random_traffic(500);
		wait_for_drain();
		repeat (2 * LIST_DEPTH + 40) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
